@@ rtl/core/spm_pkg.sv @@
// Shared types, widths and command codes of the sparse polynomial multiplier.
package spm_pkg;

  // Default values of the top-level parameters.
  localparam int MAX_TERMS_DEF  = 8;
  localparam int PROD_DEPTH_DEF = 64;
  localparam int DEG_BITS_DEF   = 8;

  // Fixed field widths.
  localparam int IN_DEG_W    = 8;
  localparam int TERM_COEF_W = 16;
  localparam int MUL_W       = 2 * TERM_COEF_W;
  localparam int SUM_W       = 17;  // degree sum for the widest DEG_BITS
  localparam int COEF_W      = 40;
  localparam int OUT_DEG_W   = 9;
  localparam int FUNC_W      = 2;

  // Command codes carried in in_tuser.
  localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MUL    = 2'd2;

  // One product term, either in flight along the chain or held in a cell.
  typedef struct packed {
    logic                     valid;
    logic [SUM_W-1:0]         deg;
    logic signed [COEF_W-1:0] coef;
  } spm_prod_t;

endpackage

@@ rtl/core/spm_cell.sv @@
// One product table cell: merges or claims a passing product, shifts down on readout.
module spm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  spm_pkg::spm_prod_t prod_in,
  output spm_pkg::spm_prod_t prod_out,
  input  spm_pkg::spm_prod_t ent_up,
  output spm_pkg::spm_prod_t ent_out
);
  import spm_pkg::*;

  spm_prod_t ent_r, ent_nxt;
  spm_prod_t pass_r, pass_nxt;

  always_comb begin
    ent_nxt  = ent_r;
    pass_nxt = prod_in;
    if (shift_en) begin
      ent_nxt        = ent_up;
      pass_nxt.valid = 1'b0;
    end else if (prod_in.valid) begin
      if (!ent_r.valid) begin
        // First free cell: this degree is new, take it here.
        ent_nxt        = prod_in;
        pass_nxt.valid = 1'b0;
      end else if (ent_r.deg == prod_in.deg) begin
        ent_nxt.coef   = ent_r.coef + prod_in.coef;
        pass_nxt.valid = 1'b0;
      end
    end
  end

  // Only the valid bits are reset; the payload simply follows its next value.
  always_ff @(posedge clk) begin
    ent_r.deg   <= ent_nxt.deg;
    ent_r.coef  <= ent_nxt.coef;
    pass_r.deg  <= pass_nxt.deg;
    pass_r.coef <= pass_nxt.coef;
    if (!rst_n) begin
      ent_r.valid  <= 1'b0;
      pass_r.valid <= 1'b0;
    end else begin
      ent_r.valid  <= ent_nxt.valid;
      pass_r.valid <= pass_nxt.valid;
    end
  end

  assign prod_out = pass_r;
  assign ent_out  = ent_r;

endmodule

@@ rtl/core/spm_chain.sv @@
// Row of product table cells with the product stream entering at cell zero.
module spm_chain #(
  parameter int PROD_DEPTH = spm_pkg::PROD_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift_en,
  input  spm_pkg::spm_prod_t inj,
  output spm_pkg::spm_prod_t head,
  output logic               next_valid,
  output logic               spill
);
  import spm_pkg::*;

  spm_prod_t pass_w [PROD_DEPTH+1];
  spm_prod_t ent_w  [PROD_DEPTH+1];

  assign pass_w[0]          = inj;
  assign ent_w[PROD_DEPTH]  = '0;

  for (genvar k = 0; k < PROD_DEPTH; k++) begin : g_cell
    spm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .prod_in  (pass_w[k]),
      .prod_out (pass_w[k+1]),
      .ent_up   (ent_w[k+1]),
      .ent_out  (ent_w[k])
    );
  end

  assign head       = ent_w[0];
  assign next_valid = ent_w[1].valid;
  // A product that leaves the last cell found neither its degree nor room.
  assign spill      = pass_w[PROD_DEPTH].valid;

endmodule

@@ rtl/core/sparse_poly_multiply.sv @@
// Sparse polynomial multiplier: term stores, product generator and output stage.
// A multiply request issues its Na*Nb products, lets them flush through the cell chain,
// then emits one result per cycle while the output is free; in_tready stays low until
// the last result is registered.
// Reset (synchronous, rst_n low) clears counts, the dropped flag, the table valid bits
// and the output valid; the term stores keep their contents and are not reset.
module sparse_poly_multiply #(
  parameter int MAX_TERMS  = spm_pkg::MAX_TERMS_DEF,
  parameter int PROD_DEPTH = spm_pkg::PROD_DEPTH_DEF,
  parameter int DEG_BITS   = spm_pkg::DEG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // term_degree[7:0], term_coeff[23:8]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // prod_degree[8:0], prod_coeff[48:9], zero pad
  output logic        out_tlast,
  output logic [1:0]  out_tuser   // empty_res[0], dropped[1]
);
  import spm_pkg::*;

  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int DRAIN_LEN = PROD_DEPTH + 2;
  localparam int DR_W      = $clog2(DRAIN_LEN);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_EMPTY = 3'd4;

  // Term stores: written at the fill count, read at the walk indexes.
  logic [DEG_BITS-1:0]           a_deg_r  [MAX_TERMS];
  logic signed [TERM_COEF_W-1:0] a_coef_r [MAX_TERMS];
  logic [DEG_BITS-1:0]           b_deg_r  [MAX_TERMS];
  logic signed [TERM_COEF_W-1:0] b_coef_r [MAX_TERMS];

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] a_cnt_r, a_cnt_nxt;
  logic [CNT_W-1:0] b_cnt_r, b_cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [DR_W-1:0]  drain_r, drain_nxt;
  spm_prod_t        inj_r, inj_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_DEG_W-1:0]     out_deg_r, out_deg_nxt;
  logic signed [COEF_W-1:0] out_coef_r, out_coef_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_empty_r, out_empty_nxt;
  logic                     out_drop_r, out_drop_nxt;

  logic                    in_acc;
  logic [FUNC_W-1:0]       func;
  logic [DEG_BITS-1:0]     term_deg;
  logic signed [TERM_COEF_W-1:0] term_coeff;
  logic                    wr_a, wr_b;
  logic                    out_free;
  logic                    shift_en;
  logic                    i_last, j_last;
  logic signed [MUL_W-1:0] mul;
  spm_prod_t               head;
  logic                    next_valid;
  logic                    spill;

  assign func       = in_tuser;
  assign term_deg   = DEG_BITS'(in_tdata[IN_DEG_W-1:0]);
  assign term_coeff = in_tdata[IN_DEG_W +: TERM_COEF_W];
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  // Walk position inside the A-outer, B-inner product order.
  assign i_last = (CNT_W'(i_r) + CNT_W'(1)) == a_cnt_r;
  assign j_last = (CNT_W'(j_r) + CNT_W'(1)) == b_cnt_r;
  assign mul    = a_coef_r[i_r] * b_coef_r[j_r];

  // The table drains toward cell zero one entry per result taken into the output.
  assign shift_en = (state_r == S_EMIT) && out_free && head.valid;

  assign wr_a = in_acc && (func == FUNC_LOAD_A) && (a_cnt_r < CNT_W'(MAX_TERMS));
  assign wr_b = in_acc && (func == FUNC_LOAD_B) && (b_cnt_r < CNT_W'(MAX_TERMS));

  always_comb begin
    state_nxt     = state_r;
    a_cnt_nxt     = a_cnt_r;
    b_cnt_nxt     = b_cnt_r;
    ovf_nxt       = ovf_r || spill;
    i_nxt         = i_r;
    j_nxt         = j_r;
    drain_nxt     = drain_r;
    inj_nxt       = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_deg_nxt   = out_deg_r;
    out_coef_nxt  = out_coef_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_drop_nxt  = out_drop_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (func)
            FUNC_LOAD_A: begin
              if (wr_a) a_cnt_nxt = a_cnt_r + CNT_W'(1);
              else      ovf_nxt   = 1'b1;
            end
            FUNC_LOAD_B: begin
              if (wr_b) b_cnt_nxt = b_cnt_r + CNT_W'(1);
              else      ovf_nxt   = 1'b1;
            end
            FUNC_MUL: begin
              i_nxt = '0;
              j_nxt = '0;
              if (a_cnt_r == '0 || b_cnt_r == '0) begin
                state_nxt = S_EMPTY;
              end else begin
                state_nxt = S_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MUL: begin
        // One product per cycle into the head of the chain.
        inj_nxt.valid = 1'b1;
        inj_nxt.deg   = SUM_W'(a_deg_r[i_r]) + SUM_W'(b_deg_r[j_r]);
        inj_nxt.coef  = {{(COEF_W - MUL_W){mul[MUL_W-1]}}, mul};
        if (j_last) begin
          j_nxt = '0;
          i_nxt = i_r + IDX_W'(1);
          if (i_last) begin
            drain_nxt = '0;
            state_nxt = S_DRAIN;
          end
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        // Let the last product reach its cell or fall off the end.
        if (drain_r == DR_W'(DRAIN_LEN - 1)) begin
          state_nxt = S_EMIT;
        end else begin
          drain_nxt = drain_r + DR_W'(1);
        end
      end
      S_EMIT: begin
        if (shift_en) begin
          out_valid_nxt = 1'b1;
          out_deg_nxt   = head.deg[OUT_DEG_W-1:0];
          out_coef_nxt  = head.coef;
          out_last_nxt  = !next_valid;
          out_empty_nxt = 1'b0;
          out_drop_nxt  = ovf_r;
          if (!next_valid) begin
            a_cnt_nxt = '0;
            b_cnt_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_deg_nxt   = '0;
          out_coef_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_empty_nxt = 1'b1;
          out_drop_nxt  = ovf_r;
          a_cnt_nxt     = '0;
          b_cnt_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    inj_r.deg  <= inj_nxt.deg;
    inj_r.coef <= inj_nxt.coef;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      drain_r     <= '0;
      inj_r.valid <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_cnt_r     <= a_cnt_nxt;
      b_cnt_r     <= b_cnt_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      drain_r     <= drain_nxt;
      inj_r.valid <= inj_nxt.valid;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_deg_r   <= out_deg_nxt;
    out_coef_r  <= out_coef_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_drop_r  <= out_drop_nxt;
    if (wr_a) begin
      a_deg_r[a_cnt_r[IDX_W-1:0]]  <= term_deg;
      a_coef_r[a_cnt_r[IDX_W-1:0]] <= term_coeff;
    end
    if (wr_b) begin
      b_deg_r[b_cnt_r[IDX_W-1:0]]  <= term_deg;
      b_coef_r[b_cnt_r[IDX_W-1:0]] <= term_coeff;
    end
  end

  // Product table: a row of cells, each holding one distinct degree.
  spm_chain #(
    .PROD_DEPTH (PROD_DEPTH)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift_en   (shift_en),
    .inj        (inj_r),
    .head       (head),
    .next_valid (next_valid),
    .spill      (spill)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_coef_r, out_deg_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_drop_r, out_empty_r};

endmodule

@@ rtl/core/spm_checker.sv @@
// Port-level checks of the sparse polynomial multiplier, bound to the top level.
module spm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);
  import spm_pkg::*;

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("stalled result changed");

  // The empty-operand result is a single zero term that closes the run.
  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && (out_tdata == '0))
    else $error("empty result malformed");

  // A multiply request blocks further requests; checked as in_tready dropping once it is taken.
  a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_MUL) |=> !in_tready)
    else $error("request accepted during multiply");

  // Reset leaves no result pending.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sparse_poly_multiply spm_checker u_spm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
